/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the key counter checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define KC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define KC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define KC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/kocnt_pkg.sv */
// ---------------------------------------------------------------------------
// Key counter package
// Function codes, limits and the item record that moves along the cell chain.
// ---------------------------------------------------------------------------
package kocnt_pkg;

  localparam int DEF_CAPACITY = 64;

  localparam int KEY_W   = 64;
  localparam int COUNT_W = 31;
  localparam int DIST_W  = 7;

  localparam logic [1:0] FUNC_INC    = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};
  localparam logic [DIST_W-1:0]  TOTAL_FIELD_MAX = {DIST_W{1'b1}};

  // One item in flight: op, key, whether a cell has served it, its count
  typedef struct packed {
    logic               vld;
    logic [1:0]         func;
    logic [KEY_W-1:0]   key;
    logic               hit;
    logic [COUNT_W-1:0] cnt;
  } item_t;

endpackage

/* sv/key_occurrence_counter_top.sv */
// ---------------------------------------------------------------------------
// Key occurrence counter
// Counts occurrences of 64-bit keys in a chain of CAPACITY entry cells.
// ---------------------------------------------------------------------------
// Request channel (req_valid/req_stall) carries func and key: increment,
// look up, or clear the table. Each item yields one result on the response
// channel (rsp_valid/rsp_stall): count, distinct_keys and refused.
// Items march through the cell chain one cell per cycle while it advances;
// each cell holds one entry and serves the item as it passes. One item can
// be accepted every cycle unless req_stall is high, set by the chain moving
// in lockstep. Items in flight see the table exactly as earlier items left
// it, so results follow arrival order.
// When a result waits at the chain end and rsp_stall is high, the whole chain
// holds and req_stall rises; otherwise the chain advances and empty slots
// pass as bubbles.
// Reset empties the table and the chain; no clearing pass is needed.
// A new key arriving while all cells hold keys is dropped and flagged.
// ---------------------------------------------------------------------------
module key_occurrence_counter_top import kocnt_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [1:0]                func,
  input  logic signed [KEY_W-1:0]   key,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic [COUNT_W-1:0]        count,
  output logic [DIST_W-1:0]         distinct_keys,
  output logic                      refused
);

  localparam int TW = $clog2(CAPACITY + 1);
  localparam int SW = (TW > DIST_W) ? TW : DIST_W;

  item_t         chain       [CAPACITY+1];
  logic [TW-1:0] chain_total [CAPACITY+1];
  logic          advance;
  logic [SW-1:0] total_wide;

  // Hold the chain only while a finished result waits to be taken
  assign advance   = !(chain[CAPACITY].vld && rsp_stall);
  assign req_stall = !advance;

  always_comb begin
    chain[0].vld  = req_valid;
    chain[0].func = func;
    chain[0].key  = key;
    chain[0].hit  = 1'b0;
    chain[0].cnt  = '0;
  end
  assign chain_total[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kocnt_cell #(
      .TW (TW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .item_prev  (chain[i]),
      .total_prev (chain_total[i]),
      .item       (chain[i+1]),
      .total      (chain_total[i+1])
    );
  end

  assign total_wide = SW'(chain_total[CAPACITY]);

  assign rsp_valid     = chain[CAPACITY].vld;
  assign count         = chain[CAPACITY].cnt;
  assign refused       = (chain[CAPACITY].func == FUNC_INC) && !chain[CAPACITY].hit;
  assign distinct_keys = (total_wide > SW'(TOTAL_FIELD_MAX)) ? TOTAL_FIELD_MAX
                                                             : total_wide[DIST_W-1:0];

endmodule

/* sv/kocnt_cell.sv */
// ---------------------------------------------------------------------------
// Key counter cell
// Holds one table entry and one pipeline slot; serves the passing item.
// ---------------------------------------------------------------------------
module kocnt_cell import kocnt_pkg::*; #(
  parameter int TW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  item_t         item_prev,
  input  logic [TW-1:0] total_prev,
  output item_t         item,
  output logic [TW-1:0] total
);

  logic               valid;
  logic               valid_next;
  logic [KEY_W-1:0]   ekey;
  logic [KEY_W-1:0]   ekey_next;
  logic [COUNT_W-1:0] ecount;
  logic [COUNT_W-1:0] ecount_next;
  item_t              item_next;
  logic [TW-1:0]      total_next;
  logic               match;

  // Keys are unique, so once an item is served no later cell can match
  assign match = valid && (ekey == item_prev.key) && !item_prev.hit;

  always_comb begin
    valid_next  = valid;
    ekey_next   = ekey;
    ecount_next = ecount;
    item_next   = item_prev;
    if (item_prev.vld) begin
      priority if (item_prev.func == FUNC_CLEAR) begin
        valid_next = 1'b0;
      end else if (match) begin
        if (item_prev.func == FUNC_INC) begin
          ecount_next   = (ecount == COUNT_MAX) ? ecount : ecount + COUNT_W'(1);
          item_next.cnt = ecount_next;
        end else begin
          item_next.cnt = ecount;
        end
        item_next.hit = 1'b1;
      end else if (item_prev.func == FUNC_INC && !valid && !item_prev.hit) begin
        // Entries fill from the head, so the first free cell means a new key
        valid_next    = 1'b1;
        ekey_next     = item_prev.key;
        ecount_next   = COUNT_W'(1);
        item_next.hit = 1'b1;
        item_next.cnt = COUNT_W'(1);
      end else begin
        // pass the item on untouched
        item_next = item_prev;
      end
    end
    total_next = total_prev + TW'(valid_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      item.vld <= 1'b0;
    end else if (advance) begin
      valid    <= valid_next;
      item.vld <= item_next.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ekey      <= ekey_next;
      ecount    <= ecount_next;
      item.func <= item_next.func;
      item.key  <= item_next.key;
      item.hit  <= item_next.hit;
      item.cnt  <= item_next.cnt;
      total     <= total_next;
    end
  end

endmodule

/* sv/kocnt_checker.sv */
// ---------------------------------------------------------------------------
// Key counter checker
// Port-level checks on the request and response channels of the counter.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kocnt_checker import kocnt_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    req_valid,
  input logic                    req_stall,
  input logic [1:0]              func,
  input logic [KEY_W-1:0]        key,
  input logic                    rsp_valid,
  input logic                    rsp_stall,
  input logic [COUNT_W-1:0]      count,
  input logic [DIST_W-1:0]       distinct_keys,
  input logic                    refused
);

  // Input side backs up only behind a stalled result
  `KC_ASSERT_IMPLY(a_stall_cause, clk, rst, req_stall, rsp_valid && rsp_stall, "req_stall without a stalled result")

  // Stalled request holds
  `KC_ASSERT_NEXT(a_req_hold, clk, rst, req_valid && req_stall, req_valid && $stable(func) && $stable(key), "stalled request changed")

  // A refused item never reports a count
  `KC_ASSERT_IMPLY(a_refused_zero, clk, rst, rsp_valid && refused, count == '0, "refused item with nonzero count")

  // A nonzero count means its key is stored
  `KC_ASSERT_IMPLY(a_count_stored, clk, rst, rsp_valid && count != '0, distinct_keys != '0, "count reported with empty table")

  // Stalled result holds
  `KC_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(count) && $stable(distinct_keys) && $stable(refused), "stalled result changed")

endmodule

bind key_occurrence_counter_top kocnt_checker u_kocnt_checker (.*);
